FILE: sv/qwn_pkg.sv
package qwn_pkg;

  localparam int unsigned FRAC = 60;
  localparam int unsigned SERIES_TERMS = 12;
  localparam logic [63:0] PI_Q60 = 64'h3243_F6A8_885A_308D;

  // (a*b) >> FRAC, truncated to 64 bits
  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // pi*j/2^sh in Q60 for ROM index j (sh = lut_bits-1)
  function automatic logic [63:0] angle_q60(input logic [63:0] j, input int unsigned sh);
    logic [63:0] ph;
    logic [63:0] pl;
    ph = PI_Q60 >> 32;
    pl = PI_Q60 & 64'h0000_0000_FFFF_FFFF;
    return ((ph * j) << (32 - sh)) + ((pl * j) >> sh);
  endfunction

  // term / ((n+1)(n+2)) for series step k
  function automatic logic [63:0] series_div(input logic [63:0] t, input int k, input bit odd);
    logic [63:0] q;
    q = t;
    if (odd) begin
      case (k)
        1:  q = t / 64'd6;
        2:  q = t / 64'd20;
        3:  q = t / 64'd42;
        4:  q = t / 64'd72;
        5:  q = t / 64'd110;
        6:  q = t / 64'd156;
        7:  q = t / 64'd210;
        8:  q = t / 64'd272;
        9:  q = t / 64'd342;
        10: q = t / 64'd420;
        11: q = t / 64'd506;
        12: q = t / 64'd600;
        default: q = t;
      endcase
    end else begin
      case (k)
        1:  q = t / 64'd2;
        2:  q = t / 64'd12;
        3:  q = t / 64'd30;
        4:  q = t / 64'd56;
        5:  q = t / 64'd90;
        6:  q = t / 64'd132;
        7:  q = t / 64'd182;
        8:  q = t / 64'd240;
        9:  q = t / 64'd306;
        10: q = t / 64'd380;
        11: q = t / 64'd462;
        12: q = t / 64'd552;
        default: q = t;
      endcase
    end
    return q;
  endfunction

  function automatic logic [63:0] series_q60(input logic [63:0] x, input bit odd);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x2 = mul_q60(x, x);
    term = odd ? x : (64'd1 << FRAC);
    sum = term;
    for (int k = 1; k <= SERIES_TERMS; k++) begin
      term = series_div(mul_q60(term, x2), k, odd);
      if (k % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  // Quarter-wave cosine magnitude, entry i of 2^(lut_bits-2)+1
  function automatic logic [31:0] rom_entry(input int unsigned i, input int unsigned lut_bits,
                                            input int unsigned out_bits);
    logic [63:0] quarter;
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] maxc;
    int unsigned drop;
    quarter = 64'd1 << (lut_bits - 2);
    maxc = (64'd1 << (out_bits - 1)) - 64'd1;
    drop = FRAC - (out_bits - 1);
    if (2 * 64'(i) <= quarter) begin
      v = series_q60(angle_q60(64'(i), lut_bits - 1), 1'b0);
    end else begin
      v = series_q60(angle_q60(quarter - 64'(i), lut_bits - 1), 1'b1);
    end
    r = (v + (64'd1 << (drop - 1))) >> drop;
    if (r > maxc) begin
      r = maxc;
    end
    return r[31:0];
  endfunction

endpackage

FILE: sv/quarter_wave_nco.sv
// Quarter-wave NCO. Each accepted request carries a signed phase increment; the block
// answers with cosine (and sine when complex_out is 1, else sine is 0) of the phase held
// before the request, then advances the ACC_BITS phase accumulator, which resets to 0.
// The top LUT_ADDR_BITS phase bits pick quadrant and a quarter-wave cosine table entry.
// Outputs are signed OUT_BITS fixed point with OUT_BITS-1 fraction bits. The block takes one
// request per clock while in_stall is low: lookup and sign fix run between the
// accumulator and the output register, and a skid register keeps input flowing for one
// extra request while the output is stalled. complex_out is written via cfg_we/cfg_wdata.
module quarter_wave_nco #(
  parameter int ACC_BITS      = 32,
  parameter int LUT_ADDR_BITS = 10,
  parameter int OUT_BITS      = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic                       cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [ACC_BITS:0]   phase_increment,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [OUT_BITS-1:0] cosine_value,
  output logic signed [OUT_BITS-1:0] sine_value
);
  import qwn_pkg::*;

  localparam int QUARTER = 1 << (LUT_ADDR_BITS - 2);
  localparam int MAG_W   = OUT_BITS - 1;
  localparam int BASE_W  = LUT_ADDR_BITS - 2;

  logic                       complex_out;
  logic [ACC_BITS-1:0]        phase_accum;
  logic [LUT_ADDR_BITS-1:0]   addr;
  logic [1:0]                 quad;
  logic [BASE_W-1:0]          base;
  logic [MAG_W-1:0]           direct_rom [QUARTER];
  logic [MAG_W-1:0]           mirror_rom [QUARTER];
  logic [MAG_W-1:0]           direct_mag;
  logic [MAG_W-1:0]           mirror_mag;
  logic [MAG_W-1:0]           cmag;
  logic [MAG_W-1:0]           smag;
  logic signed [OUT_BITS-1:0] cos_next;
  logic signed [OUT_BITS-1:0] sin_next;
  logic                       skid_valid;
  logic signed [OUT_BITS-1:0] skid_cos;
  logic signed [OUT_BITS-1:0] skid_sin;
  logic                       in_accept;
  logic                       out_take;

  for (genvar i = 0; i < QUARTER; i++) begin : g_rom
    assign direct_rom[i] = MAG_W'(rom_entry(i, LUT_ADDR_BITS, OUT_BITS));
    assign mirror_rom[i] = MAG_W'(rom_entry(QUARTER - i, LUT_ADDR_BITS, OUT_BITS));
  end

  if (ACC_BITS >= LUT_ADDR_BITS) begin : g_addr_trunc
    assign addr = phase_accum[ACC_BITS-1 -: LUT_ADDR_BITS];
  end else begin : g_addr_pad
    assign addr = {phase_accum, (LUT_ADDR_BITS - ACC_BITS)'(0)};
  end

  assign quad = addr[LUT_ADDR_BITS-1 -: 2];
  assign base = addr[BASE_W-1:0];
  assign direct_mag = direct_rom[base];
  assign mirror_mag = mirror_rom[base];
  assign cmag = quad[0] ? mirror_mag : direct_mag;
  assign smag = quad[0] ? direct_mag : mirror_mag;

  always_comb begin
    cos_next = $signed({1'b0, cmag});
    sin_next = $signed({1'b0, smag});
    if (quad[1] ^ quad[0]) begin
      cos_next = -cos_next;
    end
    if (quad[1]) begin
      sin_next = -sin_next;
    end
    if (!complex_out) begin
      sin_next = '0;
    end
  end

  assign in_stall  = skid_valid;
  assign in_accept = in_valid && !skid_valid;
  assign out_take  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      complex_out <= 1'b0;
      phase_accum <= '0;
      out_valid   <= 1'b0;
      skid_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        complex_out <= cfg_wdata;
      end
      if (in_accept) begin
        phase_accum <= phase_accum + phase_increment[ACC_BITS-1:0];
      end
      if (skid_valid) begin
        if (out_take) begin
          cosine_value <= skid_cos;
          sine_value   <= skid_sin;
          skid_valid   <= 1'b0;
        end
      end else if (in_accept) begin
        if (!out_valid || out_take) begin
          cosine_value <= cos_next;
          sine_value   <= sin_next;
          out_valid    <= 1'b1;
        end else begin
          skid_cos   <= cos_next;
          skid_sin   <= sin_next;
          skid_valid <= 1'b1;
        end
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a request while output register is empty");

  a_accept_fills_out: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> out_valid)
    else $error("accepted request did not reach the output register");

  a_skid_held: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_stall) |=> skid_valid && $stable(skid_cos) && $stable(skid_sin))
    else $error("skid contents lost while output stalled");

  a_phase_idle: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(in_accept)) |-> $stable(phase_accum))
    else $error("phase moved without an accepted request");

endmodule
